// ===== hdl/fbrc_pkg.sv =====
// shared constants for the rectangle and circle fill framebuffer
`default_nettype none

package fbrc_pkg;

  localparam int unsigned DEF_MAX_WIDTH  = 64;
  localparam int unsigned DEF_MAX_HEIGHT = 64;

  localparam int unsigned CFG_W   = 7;
  localparam int unsigned COORD_W = 16;
  localparam int unsigned PIXEL_W = 24;
  localparam int unsigned OP_W    = 2;

  // sums of two 16-bit coordinates and squared distances
  localparam int unsigned SUM_W  = COORD_W + 1;
  localparam int unsigned DIST_W = 2 * COORD_W + 1;

  localparam logic [PIXEL_W-1:0] WHITE = {PIXEL_W{1'b1}};

  localparam logic [OP_W-1:0] OP_RECT   = 2'd0;
  localparam logic [OP_W-1:0] OP_CIRCLE = 2'd1;
  localparam logic [OP_W-1:0] OP_READ   = 2'd2;
  localparam logic [OP_W-1:0] OP_NONE   = 2'd3;

  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

endpackage

`default_nettype wire

// ===== hdl/framebuffer_rect_circle_fill.sv =====
// Framebuffer with solid rectangle fill, solid circle fill and pixel read.
// After reset a clearing pass writes white to all MAX_WIDTH*MAX_HEIGHT pixels,
// one a cycle; no command is taken until it ends, configuration writes are
// taken at any time. The store has one write port, so a fill visits one pixel
// per cycle within a row: after a setup step, each row of the clipped bounding
// box takes a row setup step and then one step per column. A read passes
// through a read and a read-wait state; a rejected or empty command goes from
// setup straight to completion. The result sits in an output register, so the
// next command can be taken while it waits.
`default_nettype none

module framebuffer_rect_circle_fill
  import fbrc_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  wire                clk,
  input  wire                rst,
  // config write port
  input  wire                cfg_we,
  input  wire                cfg_index,
  input  wire  [CFG_W-1:0]   cfg_data,
  // command stream
  input  wire                s_tvalid,
  output logic               s_tready,
  input  wire  [103:0]       s_tdata,  // pos_x, pos_y, rect_width, rect_height, radius, fill_color
  input  wire  [OP_W-1:0]    s_tuser,  // operation
  // result stream
  output logic               m_tvalid,
  input  wire                m_tready,
  output logic [PIXEL_W-1:0] m_tdata,  // pixel_color
  output logic               m_tuser   // status
);

  localparam int unsigned DEPTH  = MAX_WIDTH * MAX_HEIGHT;
  localparam int unsigned ADDR_W = DEPTH > 1 ? $clog2(DEPTH) : 1;
  localparam int unsigned COL_W  = $clog2(MAX_WIDTH + 1);
  localparam int unsigned ROW_W  = $clog2(MAX_HEIGHT + 1);

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_SETUP, ST_ROW, ST_SCAN, ST_READ, ST_RWAIT, ST_DONE
  } state_t;

  state_t state;

  logic [CFG_W-1:0]   canvas_width;
  logic [CFG_W-1:0]   canvas_height;
  logic [ADDR_W-1:0]  clr_addr;

  // captured command
  logic [OP_W-1:0]    cmd_op;
  logic [COORD_W-1:0] cmd_x;
  logic [COORD_W-1:0] cmd_y;
  logic [COORD_W-1:0] cmd_w;
  logic [COORD_W-1:0] cmd_h;
  logic [COORD_W-1:0] cmd_rad;
  logic [PIXEL_W-1:0] cmd_color;

  // scan registers
  logic [COL_W-1:0]   px;
  logic [ROW_W-1:0]   py;
  logic [COL_W-1:0]   xs;
  logic [COL_W-1:0]   xe;
  logic [ROW_W-1:0]   ye;
  logic [COL_W-1:0]   col;
  logic [ROW_W-1:0]   row;
  logic [2*COORD_W-1:0] r2;
  logic [2*ROW_W-1:0] dy2;
  logic               res_status;
  logic [PIXEL_W-1:0] res_color;

  logic [COL_W-1:0]   eff_w;
  logic [ROW_W-1:0]   eff_h;
  logic               set_err;
  logic [SUM_W-1:0]   sum_x;
  logic [SUM_W-1:0]   sum_y;
  logic [COL_W-1:0]   set_xs;
  logic [ROW_W-1:0]   set_ys;
  logic [COL_W-1:0]   set_xe;
  logic [ROW_W-1:0]   set_ye;
  logic [COORD_W-1:0] ext_x;
  logic [COORD_W-1:0] ext_y;
  logic [COL_W-1:0]   dx;
  logic [ROW_W-1:0]   dy;
  logic [2*COL_W-1:0] dx2;
  logic [DIST_W-1:0]  dist2;
  logic               hit;
  logic [ADDR_W-1:0]  pix_addr;
  logic               out_free;

  logic               ram_we;
  logic [ADDR_W-1:0]  ram_waddr;
  logic [PIXEL_W-1:0] ram_wdata;
  logic [PIXEL_W-1:0] ram_rdata;

  // a register above the maximum acts as the maximum
  always_comb begin
    eff_w = (SUM_W'(canvas_width) > SUM_W'(MAX_WIDTH)) ? COL_W'(MAX_WIDTH)
                                                       : COL_W'(canvas_width);
    eff_h = (SUM_W'(canvas_height) > SUM_W'(MAX_HEIGHT)) ? ROW_W'(MAX_HEIGHT)
                                                         : ROW_W'(canvas_height);
  end

  // scan bounds of the captured command
  always_comb begin
    set_err = (cmd_op != OP_NONE) &&
              ((SUM_W'(cmd_x) >= SUM_W'(eff_w)) || (SUM_W'(cmd_y) >= SUM_W'(eff_h)));
    ext_x = (cmd_op == OP_CIRCLE) ? cmd_rad : cmd_w;
    ext_y = (cmd_op == OP_CIRCLE) ? cmd_rad : cmd_h;
    sum_x = SUM_W'(cmd_x) + SUM_W'(ext_x);
    sum_y = SUM_W'(cmd_y) + SUM_W'(ext_y);
    set_xe = (sum_x > SUM_W'(eff_w)) ? eff_w : COL_W'(sum_x);
    set_ye = (sum_y > SUM_W'(eff_h)) ? eff_h : ROW_W'(sum_y);
    if (cmd_op != OP_CIRCLE) begin
      set_xs = COL_W'(cmd_x);
      set_ys = ROW_W'(cmd_y);
    end else begin
      set_xs = (cmd_x >= cmd_rad) ? COL_W'(cmd_x - cmd_rad) : '0;
      set_ys = (cmd_y >= cmd_rad) ? ROW_W'(cmd_y - cmd_rad) : '0;
    end
  end

  // distance test of the current pixel
  always_comb begin
    dx    = (col >= px) ? (col - px) : (px - col);
    dy    = (row >= py) ? (row - py) : (py - row);
    dx2   = (2*COL_W)'(dx) * (2*COL_W)'(dx);
    dist2 = DIST_W'(dx2) + DIST_W'(dy2);
    hit   = (cmd_op == OP_RECT) || (dist2 <= DIST_W'(r2));
    pix_addr = ADDR_W'(32'(row) * MAX_WIDTH + 32'(col));
  end

  always_comb begin
    unique case (state)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr;
        ram_wdata = WHITE;
      end
      ST_SCAN: begin
        ram_we    = hit;
        ram_waddr = pix_addr;
        ram_wdata = cmd_color;
      end
      default: begin
        ram_we    = 1'b0;
        ram_waddr = pix_addr;
        ram_wdata = cmd_color;
      end
    endcase
  end

  fbrc_frame_ram #(
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (pix_addr),
    .rdata (ram_rdata)
  );

  assign s_tready = (state == ST_IDLE);
  assign out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      canvas_width  <= CFG_W'(64);
      canvas_height <= CFG_W'(64);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_WIDTH:  canvas_width  <= cfg_data;
        REG_HEIGHT: canvas_height <= cfg_data;
        default:    ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
      m_tvalid <= 1'b0;
    end else begin
      // completion reloads the output register itself
      if (m_tready && state != ST_DONE) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + ADDR_W'(1);
          if (clr_addr == ADDR_W'(DEPTH - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (s_tvalid) begin
            cmd_op    <= s_tuser;
            cmd_x     <= s_tdata[15:0];
            cmd_y     <= s_tdata[31:16];
            cmd_w     <= s_tdata[47:32];
            cmd_h     <= s_tdata[63:48];
            cmd_rad   <= s_tdata[79:64];
            cmd_color <= s_tdata[103:80];
            state     <= ST_SETUP;
          end
        end
        ST_SETUP: begin
          px         <= COL_W'(cmd_x);
          py         <= ROW_W'(cmd_y);
          xs         <= set_xs;
          xe         <= set_xe;
          ye         <= set_ye;
          row        <= (cmd_op == OP_READ) ? ROW_W'(cmd_y) : set_ys;
          col        <= COL_W'(cmd_x);
          r2         <= cmd_rad * cmd_rad;
          res_status <= set_err;
          res_color  <= '0;
          if (set_err || cmd_op == OP_NONE) begin
            state <= ST_DONE;
          end else if (cmd_op == OP_READ) begin
            state <= ST_READ;
          end else if (set_xs >= set_xe || set_ys >= set_ye) begin
            state <= ST_DONE;
          end else begin
            state <= ST_ROW;
          end
        end
        ST_ROW: begin
          dy2   <= (2*ROW_W)'(dy) * (2*ROW_W)'(dy);
          col   <= xs;
          state <= ST_SCAN;
        end
        ST_SCAN: begin
          if (col + COL_W'(1) == xe) begin
            if (row + ROW_W'(1) == ye) begin
              state <= ST_DONE;
            end else begin
              row   <= row + ROW_W'(1);
              state <= ST_ROW;
            end
          end else begin
            col <= col + COL_W'(1);
          end
        end
        ST_READ: begin
          state <= ST_RWAIT;
        end
        ST_RWAIT: begin
          res_color <= ram_rdata;
          state     <= ST_DONE;
        end
        ST_DONE: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            m_tuser  <= res_status;
            m_tdata  <= res_color;
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_scan_in_box: assert property (@(posedge clk) disable iff (rst)
    state == ST_SCAN |-> (col < xe && row < ye && col >= xs))
    else $error("scan position left the clipped box");

  a_row_in_box: assert property (@(posedge clk) disable iff (rst)
    state == ST_ROW |-> row < ye)
    else $error("row setup beyond the last row");

  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state) == ST_DONE)
    else $error("result raised outside completion");

  a_read_latency: assert property (@(posedge clk) disable iff (rst)
    state == ST_RWAIT |-> $past(state) == ST_READ)
    else $error("read data taken without a read cycle");
`endif

endmodule

`default_nettype wire

// ===== hdl/fbrc_frame_ram.sv =====
// pixel store: one write port, one read port with registered read data
`default_nettype none

module fbrc_frame_ram
  import fbrc_pkg::*;
#(
  parameter int unsigned DEPTH = DEF_MAX_WIDTH * DEF_MAX_HEIGHT
) (
  input  wire                                      clk,
  input  wire                                      we,
  input  wire  [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire  [PIXEL_W-1:0]                       wdata,
  input  wire  [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [PIXEL_W-1:0]                       rdata
);

  logic [PIXEL_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire
